FILE: rtl/ll2pc_pkg.sv
// Shared types, constants and the symbol lookup for the location code encoder.
// No dependencies; every other file in rtl/ imports this package.
package ll2pc_pkg;

  // Field widths
  localparam int LatInW    = 22;
  localparam int LonInW    = 23;
  localparam int SymW      = 7;
  localparam int DigitW    = 5;
  localparam int NumDigits = 5;
  localparam int NumSyms   = 2 * NumDigits;

  // Clamp limits in 1/8000 degree
  localparam int LatLimit = 720000;
  localparam int LonLimit = 1440000;

  // Digit steps in 1/8000 degree
  localparam int Step0 = 160000;
  localparam int Step1 = 8000;
  localparam int Step2 = 400;
  localparam int Step3 = 20;

  // Remainder widths after each digit (value below the step)
  localparam int Rem0W = 18;
  localparam int Rem1W = 13;
  localparam int Rem2W = 9;
  localparam int Rem3W = 5;

  // Reciprocal multipliers: shift = dividend bits + ceil(log2(step)),
  // multiplier = ceil(2^shift / step), exact over the whole dividend range.
  localparam int Shift0 = (LonInW - 1) + 18;
  localparam int Shift1 = Rem0W + 13;
  localparam int Shift2 = Rem1W + 9;
  localparam int Shift3 = Rem2W + 5;

  localparam longint Recip0 = ((longint'(1) << Shift0) + Step0 - 1) / Step0;
  localparam longint Recip1 = ((longint'(1) << Shift1) + Step1 - 1) / Step1;
  localparam longint Recip2 = ((longint'(1) << Shift2) + Step2 - 1) / Step2;
  localparam longint Recip3 = ((longint'(1) << Shift3) + Step3 - 1) / Step3;

  // Product widths: the quotient sits in the top DigitW bits
  localparam int Prod0W = Shift0 + DigitW;
  localparam int Prod1W = Shift1 + DigitW;
  localparam int Prod2W = Shift2 + DigitW;
  localparam int Prod3W = Shift3 + DigitW;

  // Pipeline depth: clamp, then a multiply and a subtract step per digit but the last
  localparam int LaneStages = 1 + 2 * (NumDigits - 1);
  localparam int NumStages  = LaneStages + 1;

  typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;
  typedef logic [NumSyms-1:0][SymW-1:0]     syms_t;

  // Per-stage load enables shared by both lanes and the merge register
  typedef struct packed {
    logic [LaneStages-1:0] adv;
    logic                  out_ld;
  } ll2pc_ctrl_t;

  // Map a base-20 digit to its ASCII symbol; out-of-range digits take the last one
  function automatic logic [SymW-1:0] sym_of(input logic [DigitW-1:0] digit);
    logic [SymW-1:0] sym;
    unique case (digit)
      5'd0:    sym = 7'd50;  // '2'
      5'd1:    sym = 7'd51;  // '3'
      5'd2:    sym = 7'd52;  // '4'
      5'd3:    sym = 7'd53;  // '5'
      5'd4:    sym = 7'd54;  // '6'
      5'd5:    sym = 7'd55;  // '7'
      5'd6:    sym = 7'd56;  // '8'
      5'd7:    sym = 7'd57;  // '9'
      5'd8:    sym = 7'd67;  // 'C'
      5'd9:    sym = 7'd70;  // 'F'
      5'd10:   sym = 7'd71;  // 'G'
      5'd11:   sym = 7'd72;  // 'H'
      5'd12:   sym = 7'd74;  // 'J'
      5'd13:   sym = 7'd77;  // 'M'
      5'd14:   sym = 7'd80;  // 'P'
      5'd15:   sym = 7'd81;  // 'Q'
      5'd16:   sym = 7'd82;  // 'R'
      5'd17:   sym = 7'd86;  // 'V'
      5'd18:   sym = 7'd87;  // 'W'
      default: sym = 7'd88;  // 'X'
    endcase
    return sym;
  endfunction

endpackage

FILE: rtl/ll2pc_lane.sv
// One coordinate lane: clamp and offset, then four pipelined base-20 digit steps.
// Depends on ll2pc_pkg; load enables come from the top-level stage control.
module ll2pc_lane #(
  parameter int InW   = ll2pc_pkg::LonInW,
  parameter int Limit = ll2pc_pkg::LonLimit
) (
  input  logic                    clk_i,
  input  ll2pc_pkg::ll2pc_ctrl_t  ctrl_i,
  input  logic signed [InW-1:0]   coord_i,
  output ll2pc_pkg::digits_t      digits_o
);
  import ll2pc_pkg::*;

  localparam int W = InW - 1;

  // Stage 0: clamp and offset
  logic signed [InW:0] x_ext, lim_pos, lim_neg, clamped, shifted;
  logic [W-1:0]        v_d, v_q;

  // Stage 1/2: first digit
  logic [Prod0W-1:0]   prod0;
  logic [DigitW-1:0]   q0_d, q0_q;
  logic [W-1:0]        v1_q;
  logic [Rem0W-1:0]    r0_d, r0_q;
  logic [DigitW-1:0]   dg2_q;

  // Stage 3/4: second digit
  logic [Prod1W-1:0]   prod1;
  logic [DigitW-1:0]   q1_d, q1_q;
  logic [Rem0W-1:0]    r0s3_q;
  logic [DigitW-1:0]   dg3_q;
  logic [Rem1W-1:0]    r1_d, r1_q;
  logic [1:0][DigitW-1:0] dg4_q, dg5_q;

  // Stage 5/6: third digit
  logic [Prod2W-1:0]   prod2;
  logic [DigitW-1:0]   q2_d, q2_q;
  logic [Rem1W-1:0]    r1s5_q;
  logic [Rem2W-1:0]    r2_d, r2_q;
  logic [2:0][DigitW-1:0] dg6_q, dg7_q;

  // Stage 7/8: fourth digit, remainder is the last digit
  logic [Prod3W-1:0]   prod3;
  logic [DigitW-1:0]   q3_d, q3_q;
  logic [Rem2W-1:0]    r2s7_q;
  logic [Rem3W-1:0]    r3_d, r3_q;
  logic [3:0][DigitW-1:0] dg8_q;

  // Clamp to +-Limit and shift to a non-negative count
  always_comb begin
    x_ext   = {coord_i[InW-1], coord_i};
    lim_pos = (InW + 1)'(Limit);
    lim_neg = -lim_pos;
    if (x_ext > lim_pos) begin
      clamped = lim_pos;
    end else if (x_ext < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = x_ext;
    end
    shifted = clamped + lim_pos;
    v_d     = shifted[W-1:0];
  end

  // Quotient estimates by reciprocal multiply
  always_comb begin
    prod0 = Prod0W'(v_q) * Prod0W'(Recip0);
    q0_d  = prod0[Shift0 +: DigitW];
    prod1 = Prod1W'(r0_q) * Prod1W'(Recip1);
    q1_d  = prod1[Shift1 +: DigitW];
    prod2 = Prod2W'(r1_q) * Prod2W'(Recip2);
    q2_d  = prod2[Shift2 +: DigitW];
    prod3 = Prod3W'(r2_q) * Prod3W'(Recip3);
    q3_d  = prod3[Shift3 +: DigitW];
  end

  // Remainders: subtract quotient times step
  always_comb begin
    r0_d = Rem0W'(v1_q - W'(q0_q) * W'(Step0));
    r1_d = Rem1W'(r0s3_q - Rem0W'(q1_q) * Rem0W'(Step1));
    r2_d = Rem2W'(r1s5_q - Rem1W'(q2_q) * Rem1W'(Step2));
    r3_d = Rem3W'(r2s7_q - Rem2W'(q3_q) * Rem2W'(Step3));
  end

  // Advance each stage when the shared control loads it
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[0]) begin
      v_q <= v_d;
    end
    if (ctrl_i.adv[1]) begin
      q0_q <= q0_d;
      v1_q <= v_q;
    end
    if (ctrl_i.adv[2]) begin
      dg2_q <= q0_q;
      r0_q  <= r0_d;
    end
    if (ctrl_i.adv[3]) begin
      dg3_q  <= dg2_q;
      q1_q   <= q1_d;
      r0s3_q <= r0_q;
    end
    if (ctrl_i.adv[4]) begin
      dg4_q <= {q1_q, dg3_q};
      r1_q  <= r1_d;
    end
    if (ctrl_i.adv[5]) begin
      dg5_q  <= dg4_q;
      q2_q   <= q2_d;
      r1s5_q <= r1_q;
    end
    if (ctrl_i.adv[6]) begin
      dg6_q <= {q2_q, dg5_q};
      r2_q  <= r2_d;
    end
    if (ctrl_i.adv[7]) begin
      dg7_q  <= dg6_q;
      q3_q   <= q3_d;
      r2s7_q <= r2_q;
    end
    if (ctrl_i.adv[8]) begin
      dg8_q <= {q3_q, dg7_q};
      r3_q  <= r3_d;
    end
  end

  assign digits_o = {r3_q, dg8_q};

endmodule

FILE: rtl/ll2pc_merge.sv
// Merge stage: maps both lanes' digits to symbols and interleaves them, latitude first.
// Depends on ll2pc_pkg; holds the output register.
module ll2pc_merge (
  input  logic                   clk_i,
  input  ll2pc_pkg::ll2pc_ctrl_t ctrl_i,
  input  ll2pc_pkg::digits_t     lat_digits_i,
  input  ll2pc_pkg::digits_t     lon_digits_i,
  output ll2pc_pkg::syms_t       syms_o
);
  import ll2pc_pkg::*;

  syms_t sym_d, sym_q;

  // Interleave lanes through the alphabet lookup
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      sym_d[2 * i]     = sym_of(lat_digits_i[i]);
      sym_d[2 * i + 1] = sym_of(lon_digits_i[i]);
    end
  end

  // Hold the result until the output stage is loaded again
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_ld) begin
      sym_q <= sym_d;
    end
  end

  assign syms_o = sym_q;

endmodule

FILE: rtl/latlon_to_plus_code_unit.sv
// Latitude/longitude to 10-symbol location code encoder, top level.
// Throughput: one transaction per cycle while the output is not stalled; ten
// pipeline stages each hold one, and a stall on the output lets empty stages
// upstream keep filling.
// Reset (rst_ni, asynchronous, active low) clears the stage valid flags only.
// Depends on ll2pc_pkg, ll2pc_lane and ll2pc_merge.
module latlon_to_plus_code_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [ll2pc_pkg::LatInW-1:0]   lat_units_i,
  input  logic signed [ll2pc_pkg::LonInW-1:0]   lon_units_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [ll2pc_pkg::SymW-1:0]            sym_0_o,
  output logic [ll2pc_pkg::SymW-1:0]            sym_1_o,
  output logic [ll2pc_pkg::SymW-1:0]            sym_2_o,
  output logic [ll2pc_pkg::SymW-1:0]            sym_3_o,
  output logic [ll2pc_pkg::SymW-1:0]            sym_4_o,
  output logic [ll2pc_pkg::SymW-1:0]            sym_5_o,
  output logic [ll2pc_pkg::SymW-1:0]            sym_6_o,
  output logic [ll2pc_pkg::SymW-1:0]            sym_7_o,
  output logic [ll2pc_pkg::SymW-1:0]            sym_8_o,
  output logic [ll2pc_pkg::SymW-1:0]            sym_9_o
);
  import ll2pc_pkg::*;

  logic [NumStages-1:0] vld_d, vld_q;
  logic [NumStages:0]   rdy;
  ll2pc_ctrl_t          ctrl;
  digits_t              lat_digits, lon_digits;
  syms_t                syms;

  // A stage can load when it is empty or its contents move on
  always_comb begin
    rdy[NumStages] = !out_stall_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  // Advance valid flags along the pipeline
  always_comb begin
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctrl.adv    = rdy[LaneStages-1:0];
  assign ctrl.out_ld = rdy[NumStages-1];

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NumStages-1];

  // Latitude and longitude lanes
  ll2pc_lane #(
    .InW   (LatInW),
    .Limit (LatLimit)
  ) u_lat_lane (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .coord_i  (lat_units_i),
    .digits_o (lat_digits)
  );

  ll2pc_lane #(
    .InW   (LonInW),
    .Limit (LonLimit)
  ) u_lon_lane (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .coord_i  (lon_units_i),
    .digits_o (lon_digits)
  );

  // Symbol mapping and output register
  ll2pc_merge u_merge (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .lat_digits_i (lat_digits),
    .lon_digits_i (lon_digits),
    .syms_o       (syms)
  );

  assign sym_0_o = syms[0];
  assign sym_1_o = syms[1];
  assign sym_2_o = syms[2];
  assign sym_3_o = syms[3];
  assign sym_4_o = syms[4];
  assign sym_5_o = syms[5];
  assign sym_6_o = syms[6];
  assign sym_7_o = syms[7];
  assign sym_8_o = syms[8];
  assign sym_9_o = syms[9];

  // Input is held off only when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled with an empty pipeline stage");

  // Clamped latitude never yields a top digit above nine
  a_lat_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sym_0_o <= sym_of(5'd9)))
    else $error("latitude top digit beyond clamp range");

  // Clamped longitude never yields a top digit above eighteen
  a_lon_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sym_1_o <= sym_of(5'd18)))
    else $error("longitude top digit beyond clamp range");

  // A stalled result stays in the output register
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(syms))
    else $error("output register changed under stall");

endmodule

FILE: verif/tb_latlon_to_plus_code_unit.sv
// Self-checking testbench for latlon_to_plus_code_unit: random and corner positions
// are encoded by an independent predictor and compared symbol by symbol.
// Depends on ll2pc_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb_latlon_to_plus_code_unit;
  import ll2pc_pkg::*;

  // Expected location codes, one per accepted position, oldest first
  class plus_code_scoreboard;
    syms_t pending_codes[$];
    int    errors = 0;
    string alphabet = "23456789CFGHJMPQRVWX";

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    // Clamp, offset and cut into base-20 digits, latitude symbols on even slots
    function syms_t encode_position(logic signed [LatInW-1:0] lat,
                                    logic signed [LonInW-1:0] lon);
      int    lat_v;
      int    lon_v;
      int    lat_d;
      int    lon_d;
      int    steps[5];
      syms_t code;
      steps = '{160000, 8000, 400, 20, 1};
      lat_v = lat;
      lon_v = lon;
      if (lat_v > 720000) lat_v = 720000;
      if (lat_v < -720000) lat_v = -720000;
      if (lon_v > 1440000) lon_v = 1440000;
      if (lon_v < -1440000) lon_v = -1440000;
      lat_v += 720000;
      lon_v += 1440000;
      for (int i = 0; i < 5; i++) begin
        lat_d = lat_v / steps[i];
        lon_d = lon_v / steps[i];
        lat_v = lat_v % steps[i];
        lon_v = lon_v % steps[i];
        code[2*i]   = SymW'(alphabet[lat_d]);
        code[2*i+1] = SymW'(alphabet[lon_d]);
      end
      return code;
    endfunction

    function void note_position(logic signed [LatInW-1:0] lat,
                                logic signed [LonInW-1:0] lon);
      pending_codes.push_back(encode_position(lat, lon));
    endfunction

    task check_code(syms_t got);
      syms_t want;
      if (pending_codes.size() == 0) begin
        report_mismatch("code received with no position pending");
        return;
      end
      want = pending_codes.pop_front();
      for (int i = 0; i < NumSyms; i++) begin
        if (got[i] !== want[i])
          report_mismatch($sformatf("sym_%0d got %0d expected %0d", i, got[i], want[i]));
      end
    endtask

    function int pending();
      return pending_codes.size();
    endfunction
  endclass

  localparam int CycleLimit = 200000;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic signed [LatInW-1:0] lat_units_i = '0;
  logic signed [LonInW-1:0] lon_units_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [SymW-1:0]          sym_0_o, sym_1_o, sym_2_o, sym_3_o, sym_4_o;
  logic [SymW-1:0]          sym_5_o, sym_6_o, sym_7_o, sym_8_o, sym_9_o;

  plus_code_scoreboard board;
  logic                steady_stretch = 1'b0;
  int                  cycle_count = 0;

  latlon_to_plus_code_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .lat_units_i (lat_units_i),
    .lon_units_i (lon_units_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sym_0_o     (sym_0_o),
    .sym_1_o     (sym_1_o),
    .sym_2_o     (sym_2_o),
    .sym_3_o     (sym_3_o),
    .sym_4_o     (sym_4_o),
    .sym_5_o     (sym_5_o),
    .sym_6_o     (sym_6_o),
    .sym_7_o     (sym_7_o),
    .sym_8_o     (sym_8_o),
    .sym_9_o     (sym_9_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stall the output at random, except during the steady stretch
  always @(posedge clk_i) begin
    if (!rst_ni || steady_stretch) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 13);
    end
  end

  // Record every accepted position transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      board.note_position(lat_units_i, lon_units_i);
  end

  // Check every accepted code transaction
  always @(posedge clk_i) begin
    syms_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got[0] = sym_0_o;
      got[1] = sym_1_o;
      got[2] = sym_2_o;
      got[3] = sym_3_o;
      got[4] = sym_4_o;
      got[5] = sym_5_o;
      got[6] = sym_6_o;
      got[7] = sym_7_o;
      got[8] = sym_8_o;
      got[9] = sym_9_o;
      board.check_code(got);
    end
  end

  // Present one position, optionally after a one-cycle idle gap, and hold it until taken
  task send_position(int lat, int lon);
    if (!steady_stretch && $urandom_range(0, 99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    lat_units_i <= LatInW'(lat);
    lon_units_i <= LonInW'(lon);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold off the sender until every pending code has come out
  task drain_codes();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  // Offset near a digit boundary, then back to a signed coordinate
  function int near_boundary(int span);
    int off;
    off = $urandom_range(0, (2 * span) / 400) * 400;
    if ($urandom_range(0, 1)) off += 399;
    if (off > 2 * span) off = 2 * span;
    return off - span;
  endfunction

  task send_random_position();
    int lat;
    int lon;
    int sgn;
    case ($urandom_range(0, 9))
      0, 1: begin
        lat = int'(signed'(LatInW'($urandom())));
        lon = int'(signed'(LonInW'($urandom())));
      end
      7: begin
        sgn = $urandom_range(0, 1) ? 1 : -1;
        lat = sgn * (720000 - 2 + int'($urandom_range(0, 4)));
        sgn = $urandom_range(0, 1) ? 1 : -1;
        lon = sgn * (1440000 - 2 + int'($urandom_range(0, 4)));
      end
      8: begin
        lat = near_boundary(720000);
        lon = near_boundary(1440000);
      end
      9: begin
        lat = int'($urandom_range(0, 1440000)) - 720000;
        lon = int'(signed'(LonInW'($urandom())));
      end
      default: begin
        lat = int'($urandom_range(0, 1440000)) - 720000;
        lon = int'($urandom_range(0, 2880000)) - 1440000;
      end
    endcase
    send_position(lat, lon);
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes, clamp edges, north pole, antimeridian, digit boundaries
    send_position(-2097152, -4194304);
    send_position(2097151, 4194303);
    send_position(-720000, -1440000);
    send_position(-720001, -1440001);
    send_position(720000, 1440000);
    send_position(720001, 1440001);
    send_position(719999, 1439999);
    send_position(0, 0);
    send_position(-1, -1);
    send_position(720000, 0);
    send_position(0, 1440000);
    send_position(159999 - 720000, 159999 - 1440000);
    send_position(160000 - 720000, 160000 - 1440000);
    send_position(7999 - 720000, 8000 - 1440000);
    send_position(399 - 720000, 400 - 1440000);
    send_position(19 - 720000, 20 - 1440000);
    send_position(1 - 720000, 1 - 1440000);
    send_position(-2097152, 4194303);
    send_position(2097151, -4194304);
    send_position(-1048576, 2097152);
    send_position(1048575, -2097153);
    send_position(123456, -987654);
    drain_codes();

    // Random positions; one stretch runs with no idling on either side
    for (int n = 0; n < 900; n++) begin
      if (n == 300) steady_stretch <= 1'b1;
      if (n == 500) steady_stretch <= 1'b0;
      if (n == 650) drain_codes();
      send_random_position();
    end
    drain_codes();
    repeat (20) @(posedge clk_i);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ll2pc_pkg.sv
rtl/ll2pc_lane.sv
rtl/ll2pc_merge.sv
rtl/latlon_to_plus_code_unit.sv
verif/tb_latlon_to_plus_code_unit.sv
